// ===== sv/rsp_pkg.sv =====
package rsp_pkg;

  // Pool size and the slot index width that follows from it
  localparam int SLOTS = 4;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1) + 1;

  // Request codes
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_ADD   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_LIFETIME = 2'd0;
  localparam logic [1:0] CFG_STR_MIN  = 2'd1;
  localparam logic [1:0] CFG_STR_MAX  = 2'd2;

  // Configuration reset values
  localparam logic [15:0] LIFETIME_RST = 16'd5000;
  localparam logic [15:0] STR_MIN_RST  = 16'd2048;
  localparam logic [15:0] STR_MAX_RST  = 16'd8192;

  // Accepted coordinate window, Q2.14: -0.5 .. 1.5
  localparam logic signed [15:0] UV_LOW  = -16'sd8192;
  localparam logic signed [15:0] UV_HIGH = 16'sd24576;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // capture the input transaction
    logic advance;  // tick: advance the clock
    logic scan;     // visit one slot (expire or pick)
    logic write;    // store an add, or clear all
    logic finish;   // load the result register
  } rsp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] req;
    logic       scan_last;
    logic       out_free;
  } rsp_sts_t;

endpackage

// ===== sv/ripple_slot_pool.sv =====
// Pool of event slots with a saturating millisecond clock.
// Input channel (in_valid / in_stall): one request per transaction, with
// in_req_type selecting tick, add, clear or read. The block stalls the input
// while a request is in work; a transaction is taken when in_valid is high
// and in_stall is low.
// Result channel (out_valid / out_stall): exactly one result per request,
// held in an output register until the receiver takes it. While that result
// waits, the next request is accepted and worked on; it finishes only when
// the register frees up.
// From acceptance: read goes to the done state, clear via the write state,
// add scans the slots then writes, tick advances the clock then scans. Add
// and tick visit the slots one per cycle through a single slot port, and the
// input stays stalled until the request is through the done state.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data) is always
// ready and should be written while no request is outstanding.
// Reset (rst_n low at a clock edge) frees every slot, zeroes the clock,
// restores the register defaults and empties the result register; it takes
// effect with no clearing pass.
module ripple_slot_pool
  import rsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic [15:0]        in_delta_time,
  input  logic signed [15:0] in_pos_u,
  input  logic signed [15:0] in_pos_v,
  input  logic [15:0]        in_strength,
  input  logic [1:0]         in_slot_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_accepted,
  output logic [1:0]         out_slot,
  output logic [2:0]         out_active_count,
  output logic               out_read_active,
  output logic signed [15:0] out_read_u,
  output logic signed [15:0] out_read_v,
  output logic [31:0]        out_read_time,
  output logic [15:0]        out_read_strength,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  rsp_cmd_t cmd;
  rsp_sts_t sts;

  // Sequencer
  rsp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  // Slot store, clock and result register
  rsp_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_req_type       (in_req_type),
    .in_delta_time     (in_delta_time),
    .in_pos_u          (in_pos_u),
    .in_pos_v          (in_pos_v),
    .in_strength       (in_strength),
    .in_slot_index     (in_slot_index),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_accepted      (out_accepted),
    .out_slot          (out_slot),
    .out_active_count  (out_active_count),
    .out_read_active   (out_read_active),
    .out_read_u        (out_read_u),
    .out_read_v        (out_read_v),
    .out_read_time     (out_read_time),
    .out_read_strength (out_read_strength)
  );

endmodule

// ===== sv/rsp_ctrl.sv =====
module rsp_ctrl
  import rsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_req_type,
  output logic       in_stall,
  input  rsp_sts_t   sts,
  output rsp_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADV   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       take;

  assign in_stall = (state_r != S_IDLE);
  assign take     = in_valid && (state_r == S_IDLE);

  // Commands and next state
  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    cmd.load    = take;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          unique case (in_req_type)
            REQ_TICK:  state_nxt = S_ADV;
            REQ_ADD:   state_nxt = S_SCAN;
            REQ_CLEAR: state_nxt = S_WRITE;
            REQ_READ:  state_nxt = S_DONE;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_ADV: begin
        cmd.advance = 1'b1;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = (sts.req == REQ_TICK) ? S_DONE : S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold here while the previous result still waits
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/rsp_dp.sv =====
module rsp_dp
  import rsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  rsp_cmd_t           cmd,
  output rsp_sts_t           sts,
  // input transaction fields
  input  logic [1:0]         in_req_type,
  input  logic [15:0]        in_delta_time,
  input  logic signed [15:0] in_pos_u,
  input  logic signed [15:0] in_pos_v,
  input  logic [15:0]        in_strength,
  input  logic [1:0]         in_slot_index,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_accepted,
  output logic [1:0]         out_slot,
  output logic [2:0]         out_active_count,
  output logic               out_read_active,
  output logic signed [15:0] out_read_u,
  output logic signed [15:0] out_read_v,
  output logic [31:0]        out_read_time,
  output logic [15:0]        out_read_strength
);

  // Configuration
  logic [15:0] life_r, smin_r, smax_r;

  // Captured transaction
  logic [1:0]         req_r;
  logic [15:0]        delta_r;
  logic signed [15:0] u_r, v_r;
  logic [15:0]        str_r;
  logic [1:0]         idx_r;

  // Pool state
  logic [31:0]        now_r;
  logic [31:0]        now_nxt;
  logic [SLOTS-1:0]   busy_r;
  logic [31:0]        time_r [SLOTS];
  logic signed [15:0] su_r   [SLOTS];
  logic signed [15:0] sv_r   [SLOTS];
  logic [15:0]        sstr_r [SLOTS];

  // Slot scan
  logic [IDX_W-1:0] scan_r;
  logic             found_r;
  logic [IDX_W-1:0] pick_r;
  logic [31:0]      best_r;

  // Result register
  logic out_valid_r;

  logic [IDX_W-1:0] addr;
  logic             idx_ok;
  logic             add_ok;
  logic [15:0]      str_clamp;
  logic [32:0]      now_sum;
  logic [31:0]      age;
  logic             expire;
  logic             rd_hit;

  assign cfg_ready = 1'b1;

  // One slot port: the read index on reads, the scan counter otherwise
  assign idx_ok = (5'(idx_r) < 5'(SLOTS));
  assign addr   = (req_r == REQ_READ) ? IDX_W'(idx_r) : scan_r;

  // Coordinate window and strength clamp
  assign add_ok = (u_r >= UV_LOW) && (u_r <= UV_HIGH) &&
                  (v_r >= UV_LOW) && (v_r <= UV_HIGH);
  assign str_clamp = (str_r < smin_r) ? smin_r :
                     (str_r >= smax_r) ? smax_r : str_r;

  // Saturating clock advance
  assign now_sum = {1'b0, now_r} + {17'd0, delta_r};
  assign now_nxt = now_sum[32] ? 32'hFFFF_FFFF : now_sum[31:0];

  // Age of the scanned entry
  assign age    = now_r - time_r[scan_r];
  assign expire = busy_r[scan_r] && (age > {16'd0, life_r});

  assign rd_hit = (req_r == REQ_READ) && idx_ok && busy_r[addr];

  assign sts.req       = req_r;
  assign sts.scan_last = (scan_r == IDX_W'(SLOTS - 1));
  assign sts.out_free  = !out_valid_r || !out_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      life_r <= LIFETIME_RST;
      smin_r <= STR_MIN_RST;
      smax_r <= STR_MAX_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LIFETIME: life_r <= cfg_data;
        CFG_STR_MIN:  smin_r <= cfg_data;
        CFG_STR_MAX:  smax_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control state: clock, busy flags, scan, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r       <= '0;
      busy_r      <= '0;
      scan_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        scan_r  <= '0;
        found_r <= 1'b0;
      end
      if (cmd.advance) begin
        now_r <= now_nxt;
      end
      if (cmd.scan) begin
        if (!sts.scan_last) begin
          scan_r <= scan_r + 1'b1;
        end
        if (req_r == REQ_TICK) begin
          if (expire) begin
            busy_r[scan_r] <= 1'b0;
          end
        end else if (!found_r && !busy_r[scan_r]) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.write) begin
        if (req_r == REQ_CLEAR) begin
          busy_r <= '0;
        end else if (add_ok) begin
          busy_r[pick_r] <= 1'b1;
        end
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: captured fields, victim search, slot contents, result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_req_type;
      delta_r <= in_delta_time;
      u_r     <= in_pos_u;
      v_r     <= in_pos_v;
      str_r   <= in_strength;
      idx_r   <= in_slot_index;
    end
    // first free slot, else oldest with lowest index on ties
    if (cmd.scan && (req_r != REQ_TICK) && !found_r) begin
      if (!busy_r[scan_r]) begin
        pick_r <= scan_r;
      end else if ((scan_r == '0) || (time_r[scan_r] < best_r)) begin
        pick_r <= scan_r;
        best_r <= time_r[scan_r];
      end
    end
    if (cmd.write && (req_r == REQ_ADD) && add_ok) begin
      time_r[pick_r] <= now_r;
      su_r[pick_r]   <= u_r;
      sv_r[pick_r]   <= v_r;
      sstr_r[pick_r] <= str_clamp;
    end
    if (cmd.finish) begin
      out_accepted      <= (req_r == REQ_ADD) && add_ok;
      out_slot          <= ((req_r == REQ_ADD) && add_ok) ? 2'(pick_r) : 2'd0;
      out_active_count  <= 3'($countones(busy_r));
      out_read_active   <= rd_hit;
      out_read_u        <= rd_hit ? su_r[addr]   : 16'sd0;
      out_read_v        <= rd_hit ? sv_r[addr]   : 16'sd0;
      out_read_time     <= rd_hit ? time_r[addr] : 32'd0;
      out_read_strength <= rd_hit ? sstr_r[addr] : 16'd0;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // A stored add leaves its slot active
  a_add_marks_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write && (req_r == REQ_ADD) && add_ok |=> busy_r[$past(pick_r)])
    else $error("accepted add did not mark its slot active");

  // Clear leaves no slot active
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write && (req_r == REQ_CLEAR) |=> (busy_r == '0))
    else $error("clear left an active slot");

  // The result register is never overwritten while it waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while stalled");

  // The clock never runs backward
  a_clock_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |=> (now_r >= $past(now_r)))
    else $error("time counter decreased");
`endif

endmodule

// ===== sim/tb_ripple_slot_pool.sv =====
module tb_ripple_slot_pool;
  import rsp_pkg::*;

  // One result of the pool, in port order
  typedef struct packed {
    logic        accepted;
    logic [1:0]  slot;
    logic [2:0]  active_count;
    logic        read_active;
    logic [15:0] read_u;
    logic [15:0] read_v;
    logic [31:0] read_time;
    logic [15:0] read_strength;
  } pool_result_t;

  localparam int SETTLE_CYCLES = 12;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_req_type;
  logic [15:0]        in_delta_time;
  logic signed [15:0] in_pos_u;
  logic signed [15:0] in_pos_v;
  logic [15:0]        in_strength;
  logic [1:0]         in_slot_index;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_accepted;
  logic [1:0]         out_slot;
  logic [2:0]         out_active_count;
  logic               out_read_active;
  logic signed [15:0] out_read_u;
  logic signed [15:0] out_read_v;
  logic [31:0]        out_read_time;
  logic [15:0]        out_read_strength;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;

  // Shadow copy of the pool and its registers
  logic [31:0] now_ms;
  logic        busy [SLOTS];
  logic        written [SLOTS];
  logic [31:0] entry_time [SLOTS];
  logic [15:0] entry_u [SLOTS];
  logic [15:0] entry_v [SLOTS];
  logic [15:0] entry_str [SLOTS];
  logic [15:0] life_ms;
  logic [15:0] str_lo;
  logic [15:0] str_hi;

  pool_result_t results_due [$];
  int           errors;
  bit           idle_on;
  bit           stall_on;
  int           stall_left = 0;

  ripple_slot_pool dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_delta_time     (in_delta_time),
    .in_pos_u          (in_pos_u),
    .in_pos_v          (in_pos_v),
    .in_strength       (in_strength),
    .in_slot_index     (in_slot_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_accepted      (out_accepted),
    .out_slot          (out_slot),
    .out_active_count  (out_active_count),
    .out_read_active   (out_read_active),
    .out_read_u        (out_read_u),
    .out_read_v        (out_read_v),
    .out_read_time     (out_read_time),
    .out_read_strength (out_read_strength),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Apply one request to the shadow pool and return the result it gives
  function automatic pool_result_t apply_request(logic [1:0] req, logic [15:0] delta,
      logic signed [15:0] u, logic signed [15:0] v, logic [15:0] str, logic [1:0] idx);
    pool_result_t r;
    int           k;
    int           n;
    logic [15:0]  s;
    logic [31:0]  age;
    r = '0;
    k = -1;
    n = 0;
    case (req)
      REQ_TICK: begin
        // saturating clock, then expire old entries
        if (now_ms > 32'hFFFF_FFFF - delta) now_ms = 32'hFFFF_FFFF;
        else now_ms = now_ms + delta;
        for (int i = 0; i < SLOTS; i++) begin
          age = now_ms - entry_time[i];
          if (busy[i] && age > life_ms) busy[i] = 1'b0;
        end
      end
      REQ_ADD: begin
        if (u >= UV_LOW && u <= UV_HIGH && v >= UV_LOW && v <= UV_HIGH) begin
          // first free slot, else oldest with lowest index on ties
          for (int i = 0; i < SLOTS; i++)
            if (!busy[i] && k < 0) k = i;
          if (k < 0) begin
            k = 0;
            for (int i = 1; i < SLOTS; i++)
              if (entry_time[i] < entry_time[k]) k = i;
          end
          if (str < str_lo) s = str_lo;
          else if (!(str < str_hi)) s = str_hi;
          else s = str;
          entry_u[k] = u;
          entry_v[k] = v;
          entry_time[k] = now_ms;
          entry_str[k] = s;
          busy[k] = 1'b1;
          written[k] = 1'b1;
          r.accepted = 1'b1;
          r.slot = 2'(k);
        end
      end
      REQ_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) busy[i] = 1'b0;
      end
      REQ_READ: begin
        if (busy[idx]) begin
          r.read_active = 1'b1;
          r.read_u = entry_u[idx];
          r.read_v = entry_v[idx];
          r.read_time = entry_time[idx];
          r.read_strength = entry_str[idx];
        end
      end
    endcase
    for (int i = 0; i < SLOTS; i++)
      if (busy[i]) n++;
    r.active_count = 3'(n);
    return r;
  endfunction

  // Send one request; the expected result is queued at acceptance
  task automatic send_request(logic [1:0] req, logic [15:0] delta, logic [15:0] u,
      logic [15:0] v, logic [15:0] str, logic [1:0] idx);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_delta_time <= delta;
    in_pos_u      <= u;
    in_pos_v      <= v;
    in_strength   <= str;
    in_slot_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    results_due.push_back(apply_request(req, delta, u, v, str, idx));
  endtask

  // Stop sending and wait until every queued result has arrived
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      CFG_LIFETIME: life_ms = data;
      CFG_STR_MIN:  str_lo = data;
      CFG_STR_MAX:  str_hi = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] life, logic [15:0] lo, logic [15:0] hi);
    wait_drained();
    write_reg(CFG_LIFETIME, life);
    write_reg(CFG_STR_MIN, lo);
    write_reg(CFG_STR_MAX, hi);
  endtask

  // Random coordinate: mostly inside the window, some at its edges, some anywhere
  function automatic logic [15:0] rand_coord();
    logic [15:0] c;
    case ($urandom_range(0, 9))
      0: c = 16'($urandom_range(0, 65535));
      1: begin
        case ($urandom_range(0, 3))
          0: c = UV_LOW;
          1: c = UV_LOW - 16'sd1;
          2: c = UV_HIGH;
          default: c = UV_HIGH + 16'sd1;
        endcase
      end
      default: c = 16'($urandom_range(0, 32768)) - 16'd8192;
    endcase
    return c;
  endfunction

  // Random slot among those written at least once, -1 if none
  function automatic int pick_written_slot();
    int start;
    start = $urandom_range(0, SLOTS - 1);
    for (int i = 0; i < SLOTS; i++)
      if (written[(start + i) % SLOTS]) return (start + i) % SLOTS;
    return -1;
  endfunction

  task automatic send_random();
    int          pick;
    int          rd;
    logic [15:0] d;
    logic [15:0] s;
    pick = $urandom_range(0, 99);
    rd = pick_written_slot();
    if ($urandom_range(0, 3) == 0) d = 16'($urandom_range(0, 65535));
    else d = 16'($urandom_range(0, life_ms / 4 + 1));
    case ($urandom_range(0, 2))
      0: s = 16'($urandom_range(0, 65535));
      1: s = 16'($urandom_range(0, 16384));
      default: begin
        case ($urandom_range(0, 3))
          0: s = str_lo - 16'd1;
          1: s = str_lo;
          2: s = str_hi - 16'd1;
          default: s = str_hi;
        endcase
      end
    endcase
    if (pick < 45 || (pick >= 70 && pick < 95 && rd < 0))
      send_request(REQ_ADD, d, rand_coord(), rand_coord(), s, 2'($urandom_range(0, 3)));
    else if (pick < 70)
      send_request(REQ_TICK, d, rand_coord(), rand_coord(), s, 2'($urandom_range(0, 3)));
    else if (pick < 95)
      send_request(REQ_READ, d, rand_coord(), rand_coord(), s, 2'(rd));
    else
      send_request(REQ_CLEAR, d, rand_coord(), rand_coord(), s, 2'($urandom_range(0, 3)));
  endtask

  // Coordinate window, strength clamp at reset bounds, replacement on a full pool
  task automatic test_window_and_clamp();
    send_request(REQ_ADD, 16'd0, UV_LOW, UV_HIGH, 16'd0, 2'd0);
    send_request(REQ_ADD, 16'd0, UV_LOW - 16'sd1, 16'd0, 16'd4096, 2'd0);
    send_request(REQ_ADD, 16'd0, 16'd0, UV_HIGH + 16'sd1, 16'd4096, 2'd0);
    send_request(REQ_ADD, 16'd0, 16'h8000, 16'h7FFF, 16'hFFFF, 2'd0);
    send_request(REQ_ADD, 16'd0, UV_HIGH, UV_LOW, 16'hFFFF, 2'd0);
    send_request(REQ_ADD, 16'd0, 16'h1000, 16'h1000, 16'd8191, 2'd0);
    send_request(REQ_TICK, 16'd100, 16'd0, 16'd0, 16'd0, 2'd0);
    send_request(REQ_ADD, 16'd0, 16'd0, 16'd0, 16'd2048, 2'd0);
    // pool full, three entries share the oldest time
    send_request(REQ_ADD, 16'd0, 16'h2AAA, 16'h1555, 16'd5000, 2'd0);
    for (int i = 0; i < SLOTS; i++)
      send_request(REQ_READ, 16'd0, 16'd0, 16'd0, 16'd0, 2'(i));
  endtask

  // Expiry exactly at the lifetime, read of a freed slot, clear
  task automatic test_expiry();
    send_request(REQ_TICK, 16'd4900, 16'd0, 16'd0, 16'd0, 2'd0);
    send_request(REQ_TICK, 16'd1, 16'd0, 16'd0, 16'd0, 2'd0);
    send_request(REQ_READ, 16'd0, 16'd0, 16'd0, 16'd0, 2'd1);
    send_request(REQ_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0, 2'd0);
    send_request(REQ_READ, 16'd0, 16'd0, 16'd0, 16'd0, 2'd3);
    send_request(REQ_TICK, 16'hFFFF, 16'd0, 16'd0, 16'd0, 2'd0);
  endtask

  // Lower clamp bound above the upper one, zero lifetime
  task automatic test_reversed_clamp();
    set_config(16'd0, 16'd9000, 16'd4000);
    send_request(REQ_ADD, 16'd0, 16'd0, 16'd0, 16'd8999, 2'd0);
    send_request(REQ_ADD, 16'd0, 16'd0, 16'd0, 16'd9000, 2'd0);
    send_request(REQ_TICK, 16'd0, 16'd0, 16'd0, 16'd0, 2'd0);
    send_request(REQ_TICK, 16'd1, 16'd0, 16'd0, 16'd0, 2'd0);
    send_request(REQ_READ, 16'd0, 16'd0, 16'd0, 16'd0, 2'd0);
  endtask

  // Random traffic over several register settings; the last phase runs without idling or output stalls
  task automatic test_random_traffic();
    logic [15:0] lives [5] = '{16'd3000, 16'd0, 16'hFFFF, 16'd200, LIFETIME_RST};
    logic [15:0] lows [5]  = '{16'd2048, 16'd0, 16'hFFFF, 16'd9000, STR_MIN_RST};
    logic [15:0] highs [5] = '{16'd8192, 16'hFFFF, 16'd0, 16'd4000, STR_MAX_RST};
    for (int p = 0; p < 5; p++) begin
      set_config(lives[p], lows[p], highs[p]);
      if (p == 4) begin
        idle_on = 1'b0;
        stall_on = 1'b0;
      end
      repeat (85) send_random();
    end
  endtask

  // Largest lifetime: an entry aged exactly that long survives, one more ms frees it
  task automatic test_long_ticks();
    set_config(16'hFFFF, STR_MIN_RST, STR_MAX_RST);
    send_request(REQ_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0, 2'd0);
    send_request(REQ_ADD, 16'd0, 16'h0100, 16'h0200, 16'd4096, 2'd0);
    send_request(REQ_TICK, 16'hFFFF, 16'd0, 16'd0, 16'd0, 2'd0);
    send_request(REQ_READ, 16'd0, 16'd0, 16'd0, 16'd0, 2'd0);
    send_request(REQ_TICK, 16'd1, 16'd0, 16'd0, 16'd0, 2'd0);
    send_request(REQ_READ, 16'd0, 16'd0, 16'd0, 16'd0, 2'd0);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 'h%0h, got 'h%0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Result channel receiver: random bursts of stall
  always @(posedge clk) begin
    if (!stall_on) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    pool_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $display("%0t: result transaction with none expected", $time);
        errors++;
      end else begin
        want = results_due.pop_front();
        check_field("accepted", want.accepted, out_accepted);
        check_field("slot", want.slot, out_slot);
        check_field("active_count", want.active_count, out_active_count);
        check_field("read_active", want.read_active, out_read_active);
        check_field("read_u", want.read_u, $unsigned(out_read_u));
        check_field("read_v", want.read_v, $unsigned(out_read_v));
        check_field("read_time", want.read_time, out_read_time);
        check_field("read_strength", want.read_strength, out_read_strength);
      end
    end
  end

  // Main sequence
  initial begin
    errors = 0;
    idle_on = 1'b1;
    stall_on = 1'b1;
    now_ms = '0;
    life_ms = LIFETIME_RST;
    str_lo = STR_MIN_RST;
    str_hi = STR_MAX_RST;
    for (int i = 0; i < SLOTS; i++) begin
      busy[i] = 1'b0;
      written[i] = 1'b0;
      entry_time[i] = '0;
      entry_u[i] = '0;
      entry_v[i] = '0;
      entry_str[i] = '0;
    end
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_req_type   <= REQ_TICK;
    in_delta_time <= '0;
    in_pos_u      <= '0;
    in_pos_v      <= '0;
    in_strength   <= '0;
    in_slot_index <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_LIFETIME;
    cfg_data      <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_window_and_clamp();
    test_expiry();
    test_reversed_clamp();
    test_random_traffic();
    test_long_ticks();
    wait_drained();

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit
  initial begin
    #24_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
